FILE: rtl/plsf_pkg.sv
// Shared constants, command types and fixed-point helpers for the least-squares fit core.
`default_nettype none
package plsf_pkg;

	localparam int MAX_DEGREE = 7;
	localparam int NDIM       = MAX_DEGREE + 1;
	localparam int NPOW       = 2 * MAX_DEGREE + 1;
	localparam int IDX_W      = $clog2(NDIM);
	localparam int PW         = $clog2(NPOW);
	localparam int AW         = 1 + 2 * IDX_W;
	localparam int RAM_DEPTH  = 2 * NDIM * NDIM;

	localparam logic [63:0] FX_ONE  = 64'h0000_0001_0000_0000;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_ACC_PS,
		OP_MUL_BP,
		OP_ACC_MS,
		OP_MUL_PT,
		OP_SET_P,
		OP_INIT_W,
		OP_INIT_ONE,
		OP_INIT_ZERO,
		OP_PIV_CLR,
		OP_PIV_CMP,
		OP_HOLD,
		OP_WR_RD,
		OP_WR_HOLD,
		OP_DIV_START,
		OP_DIV_ONE,
		OP_SET_C,
		OP_MUL_C,
		OP_WR_SUB,
		OP_WR_MUL,
		OP_ACC_CLR,
		OP_MUL_MS,
		OP_ACC_X,
		OP_EMIT,
		OP_CLEAR
	} dp_op_t;

	typedef struct packed {
		dp_op_t          op;
		logic            re;
		logic [AW-1:0]   addr;
		logic [PW-1:0]   idx;
		logic            last;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic piv_gt;
		logic out_busy;
	} stat_t;

	function automatic logic [63:0] mag(logic [63:0] a);
		return a[63] ? (64'd0 - a) : a;
	endfunction

	function automatic logic [63:0] from_mag(logic neg, logic [63:0] m);
		if (!neg)
			return m[63] ? S64_MAX : m;
		return m[63] ? S64_MIN : (64'd0 - m);
	endfunction

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63])
			r = a[63] ? S64_MIN : S64_MAX;
		return r;
	endfunction

	function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		r = a - b;
		if (a[63] != b[63] && r[63] != a[63])
			r = a[63] ? S64_MIN : S64_MAX;
		return r;
	endfunction

	function automatic logic [AW-1:0] ram_addr(logic sel, logic [IDX_W-1:0] row,
		logic [IDX_W-1:0] col);
		return {sel, row, col};
	endfunction

endpackage
`default_nettype wire

FILE: rtl/plsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module plsf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/plsf_mul.sv
// Multi-cycle Q32.32 multiplier: four 32x32 partial products, floor rounding, saturation.
`default_nettype none
module plsf_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             busy,
	output logic             done,
	output logic      [63:0] res
);
	import plsf_pkg::*;

	logic [63:0]  ma_q, mb_q, res_q;
	logic         neg_q, busy_q, done_q;
	logic [127:0] prod_q;
	logic [2:0]   cnt_q;

	logic [31:0]  ah, bh;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [63:0]  hi, lo, q, fin;
	logic         over;

	always_comb begin
		ah = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
		bh = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
		pp = 64'(ah) * 64'(bh);
		case (cnt_q[1:0])
			2'd0: pp_sh = {64'd0, pp};
			2'd3: pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	// round toward minus infinity: a negative result with dropped bits moves away from zero
	always_comb begin
		hi   = prod_q[127:64];
		lo   = prod_q[63:0];
		q    = {hi[31:0], lo[63:32]};
		over = |hi[63:32];
		if (neg_q && (|lo[31:0]) && !over) begin
			if (&q)
				over = 1'b1;
			else
				q = q + 64'd1;
		end
		if (over)
			fin = neg_q ? S64_MIN : S64_MAX;
		else
			fin = from_mag(neg_q, q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q   <= mag(a);
			mb_q   <= mag(b);
			neg_q  <= a[63] ^ b[63];
			prod_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4)
				res_q <= fin;
			else
				prod_q <= prod_q + pp_sh;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

FILE: rtl/plsf_div.sv
// Radix-2 restoring Q32.32 divider: one quotient bit per cycle, truncation, saturation.
`default_nettype none
module plsf_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             busy,
	output logic             done,
	output logic             zero,
	output logic      [63:0] res
);
	import plsf_pkg::*;

	logic [63:0]  ub_q, r_q, res_q;
	logic [127:0] n_q, q_q;
	logic [7:0]   cnt_q;
	logic         neg_q, busy_q, done_q, zero_q;

	logic [63:0]  r2, rn;
	logic         take;

	always_comb begin
		r2   = {r_q[62:0], n_q[127]};
		take = r_q[63] | (r2 >= ub_q);
		rn   = take ? (r2 - ub_q) : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 8'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 8'd0;
				if (b == 64'd0)
					done_q <= 1'b1;
				else
					busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q[7]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (b == 64'd0);
			res_q  <= '0;
			ub_q   <= mag(b);
			neg_q  <= a[63] ^ b[63];
			n_q    <= {32'd0, mag(a), 32'd0};
			r_q    <= '0;
			q_q    <= '0;
		end else if (busy_q) begin
			if (cnt_q[7]) begin
				if (|q_q[127:64])
					res_q <= neg_q ? S64_MIN : S64_MAX;
				else
					res_q <= from_mag(neg_q, q_q[63:0]);
			end else begin
				n_q <= {n_q[126:0], 1'b0};
				r_q <= rn;
				q_q <= {q_q[126:0], take};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign zero = zero_q;
	assign res  = res_q;

endmodule
`default_nettype wire

FILE: rtl/plsf_dp.sv
// Datapath: sums, matrix RAM, shared multiplier and divider, output register.
`default_nettype none
module plsf_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire plsf_pkg::cmd_t       cmd,
	output plsf_pkg::stat_t           stat,
	input  wire logic signed [31:0]   sample_t,
	input  wire logic signed [31:0]   sample_b,
	output logic                      coeff_valid,
	input  wire logic                 coeff_stall,
	output logic              [2:0]   coeff_index,
	output logic signed       [63:0]  coeff_value,
	output logic                      last_coeff,
	output logic                      singular
);
	import plsf_pkg::*;

	logic [63:0] ps_q [NPOW];
	logic [63:0] ms_q [NDIM];
	logic [63:0] t_q, b_q, p_q, hold_q, coef_q, acc_q, bm_q;
	logic        sing_q;
	logic        coeff_valid_q, last_coeff_q, singular_q;
	logic [2:0]  coeff_index_q;
	logic [63:0] coeff_value_q;

	logic [63:0] rdata, wdata, mul_a, mul_b, mul_res, div_a, div_res;
	logic        we, mul_start, mul_busy, mul_done, div_start, div_busy, div_done, div_zero;
	logic [IDX_W-1:0] ms_idx;

	assign ms_idx = cmd.idx[IDX_W-1:0];

	always_comb begin
		we    = 1'b0;
		wdata = rdata;
		case (cmd.op)
			OP_INIT_W:    begin we = 1'b1; wdata = ps_q[cmd.idx]; end
			OP_INIT_ONE:  begin we = 1'b1; wdata = FX_ONE; end
			OP_INIT_ZERO: begin we = 1'b1; wdata = '0; end
			OP_WR_RD:     begin we = 1'b1; wdata = rdata; end
			OP_WR_HOLD:   begin we = 1'b1; wdata = hold_q; end
			OP_WR_SUB:    begin we = 1'b1; wdata = sat_sub(rdata, mul_res); end
			OP_WR_MUL:    begin we = 1'b1; wdata = mul_res; end
			default:      ;
		endcase
	end

	always_comb begin
		mul_start = 1'b1;
		mul_a     = coef_q;
		mul_b     = rdata;
		case (cmd.op)
			OP_MUL_BP: begin mul_a = b_q; mul_b = p_q; end
			OP_MUL_PT: begin mul_a = p_q; mul_b = t_q; end
			OP_MUL_C:  begin mul_a = coef_q; mul_b = rdata; end
			OP_MUL_MS: begin mul_a = rdata; mul_b = ms_q[ms_idx]; end
			default:   mul_start = 1'b0;
		endcase
	end

	assign div_start = (cmd.op == OP_DIV_START) || (cmd.op == OP_DIV_ONE);
	assign div_a     = (cmd.op == OP_DIV_ONE) ? FX_ONE : hold_q;

	plsf_ram #(.WIDTH(64), .DEPTH(RAM_DEPTH)) u_mat (
		.clk   (clk),
		.we    (we),
		.waddr (cmd.addr),
		.wdata (wdata),
		.re    (cmd.re),
		.raddr (cmd.addr),
		.rdata (rdata)
	);

	plsf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.res    (mul_res)
	);

	plsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (div_a),
		.b      (rdata),
		.busy   (div_busy),
		.done   (div_done),
		.zero   (div_zero),
		.res    (div_res)
	);

	assign stat.mul_done = mul_done;
	assign stat.div_done = div_done;
	assign stat.piv_gt   = mag(rdata) > bm_q;
	assign stat.out_busy = coeff_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NPOW; n++)
				ps_q[n] <= '0;
			for (int n = 0; n < NDIM; n++)
				ms_q[n] <= '0;
			sing_q        <= 1'b0;
			coeff_valid_q <= 1'b0;
		end else begin
			if (coeff_valid_q && !coeff_stall)
				coeff_valid_q <= 1'b0;
			case (cmd.op)
				OP_ACC_PS: ps_q[cmd.idx] <= sat_add(ps_q[cmd.idx], p_q);
				OP_ACC_MS: ms_q[ms_idx]  <= sat_add(ms_q[ms_idx], mul_res);
				OP_SET_C:  sing_q        <= sing_q | div_zero;
				OP_EMIT:   coeff_valid_q <= 1'b1;
				OP_CLEAR: begin
					for (int n = 0; n < NPOW; n++)
						ps_q[n] <= '0;
					for (int n = 0; n < NDIM; n++)
						ms_q[n] <= '0;
					sing_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				t_q <= {{16{sample_t[31]}}, sample_t, 16'd0};
				b_q <= {{16{sample_b[31]}}, sample_b, 16'd0};
				p_q <= FX_ONE;
			end
			OP_SET_P:   p_q    <= mul_res;
			OP_PIV_CLR: bm_q   <= '0;
			OP_PIV_CMP: if (stat.piv_gt) bm_q <= mag(rdata);
			OP_HOLD:    hold_q <= rdata;
			OP_SET_C:   coef_q <= div_res;
			OP_ACC_CLR: acc_q  <= '0;
			OP_ACC_X:   acc_q  <= sat_add(acc_q, mul_res);
			OP_EMIT: begin
				coeff_index_q <= 3'(cmd.idx);
				coeff_value_q <= acc_q;
				last_coeff_q  <= cmd.last;
				singular_q    <= sing_q;
			end
			default: ;
		endcase
	end

	assign coeff_valid = coeff_valid_q;
	assign coeff_index = coeff_index_q;
	assign coeff_value = coeff_value_q;
	assign last_coeff  = last_coeff_q;
	assign singular    = singular_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> !coeff_valid_q)
		else $error("coefficient loaded over an unsent one");

	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_busy)
		else $error("multiplier started while busy");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

endmodule
`default_nettype wire

FILE: rtl/plsf_ctrl.sv
// Controller: sample accumulation sequence, Gauss-Jordan inversion and coefficient output.
`default_nettype none
module plsf_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            degree_we,
	input  wire logic [2:0]      degree_wdata,
	input  wire logic            sample_valid,
	output logic                 sample_stall,
	input  wire logic            last_sample,
	input  wire plsf_pkg::stat_t stat,
	output plsf_pkg::cmd_t       cmd
);
	import plsf_pkg::*;

	typedef enum logic [39:0] {
		S_IDLE    = 40'h1 << 0,
		S_ACC     = 40'h1 << 1,
		S_MB      = 40'h1 << 2,
		S_MB_W    = 40'h1 << 3,
		S_PT      = 40'h1 << 4,
		S_PT_W    = 40'h1 << 5,
		S_INIT    = 40'h1 << 6,
		S_INIT2   = 40'h1 << 7,
		S_PIV0    = 40'h1 << 8,
		S_PIV_RD  = 40'h1 << 9,
		S_PIV_CMP = 40'h1 << 10,
		S_SWP_CHK = 40'h1 << 11,
		S_SW_RA   = 40'h1 << 12,
		S_SW_RB   = 40'h1 << 13,
		S_SW_WA   = 40'h1 << 14,
		S_SW_WB   = 40'h1 << 15,
		S_ELIM0   = 40'h1 << 16,
		S_DV_RA   = 40'h1 << 17,
		S_DV_RB   = 40'h1 << 18,
		S_DV_GO   = 40'h1 << 19,
		S_DV_W    = 40'h1 << 20,
		S_RO_RS   = 40'h1 << 21,
		S_RO_MG   = 40'h1 << 22,
		S_RO_MW   = 40'h1 << 23,
		S_RO_RD   = 40'h1 << 24,
		S_RO_WR   = 40'h1 << 25,
		S_BK_K    = 40'h1 << 26,
		S_SC_RD   = 40'h1 << 27,
		S_SC_GO   = 40'h1 << 28,
		S_SC_W    = 40'h1 << 29,
		S_SC_RS   = 40'h1 << 30,
		S_SC_MG   = 40'h1 << 31,
		S_SC_MW   = 40'h1 << 32,
		S_SC_WR   = 40'h1 << 33,
		S_OUT0    = 40'h1 << 34,
		S_OU_RD   = 40'h1 << 35,
		S_OU_MG   = 40'h1 << 36,
		S_OU_MW   = 40'h1 << 37,
		S_OU_EM   = 40'h1 << 38,
		S_CLR     = 40'h1 << 39
	} state_t;

	state_t           state_q, state_d;
	logic [PW-1:0]    pk_q, pk_d;
	logic [IDX_W-1:0] k_q, k_d, i_q, i_d, j_q, j_d, best_q, best_d, n_eff;
	logic             sel_q, sel_d, bk_q, bk_d, last_q, last_d;
	logic [2:0]       degree_q;

	always_comb begin
		if (32'(degree_q) > MAX_DEGREE)
			n_eff = IDX_W'(MAX_DEGREE);
		else
			n_eff = IDX_W'(degree_q);
	end

	assign sample_stall = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		pk_d     = pk_q;
		k_d      = k_q;
		i_d      = i_q;
		j_d      = j_q;
		best_d   = best_q;
		sel_d    = sel_q;
		bk_d     = bk_q;
		last_d   = last_q;
		cmd.op   = OP_NONE;
		cmd.re   = 1'b0;
		cmd.addr = '0;
		cmd.idx  = '0;
		cmd.last = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (sample_valid) begin
					cmd.op  = OP_LOAD;
					pk_d    = '0;
					last_d  = last_sample;
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.op  = OP_ACC_PS;
				cmd.idx = pk_q;
				state_d = (32'(pk_q) < NDIM) ? S_MB : S_PT;
			end
			S_MB: begin
				cmd.op  = OP_MUL_BP;
				state_d = S_MB_W;
			end
			S_MB_W: begin
				if (stat.mul_done) begin
					cmd.op  = OP_ACC_MS;
					cmd.idx = pk_q;
					state_d = S_PT;
				end
			end
			S_PT: begin
				if (32'(pk_q) == NPOW - 1) begin
					i_d     = '0;
					j_d     = '0;
					state_d = last_q ? S_INIT : S_IDLE;
				end else begin
					cmd.op  = OP_MUL_PT;
					state_d = S_PT_W;
				end
			end
			S_PT_W: begin
				if (stat.mul_done) begin
					cmd.op  = OP_SET_P;
					pk_d    = pk_q + PW'(1);
					state_d = S_ACC;
				end
			end
			S_INIT: begin
				cmd.op   = OP_INIT_W;
				cmd.addr = ram_addr(1'b0, i_q, j_q);
				cmd.idx  = PW'(i_q) + PW'(j_q);
				state_d  = S_INIT2;
			end
			S_INIT2: begin
				cmd.op   = (i_q == j_q) ? OP_INIT_ONE : OP_INIT_ZERO;
				cmd.addr = ram_addr(1'b1, i_q, j_q);
				state_d  = S_INIT;
				if (j_q == n_eff) begin
					j_d = '0;
					if (i_q == n_eff) begin
						k_d     = '0;
						state_d = S_PIV0;
					end else begin
						i_d = i_q + IDX_W'(1);
					end
				end else begin
					j_d = j_q + IDX_W'(1);
				end
			end
			S_PIV0: begin
				cmd.op  = OP_PIV_CLR;
				best_d  = k_q;
				i_d     = k_q;
				state_d = S_PIV_RD;
			end
			S_PIV_RD: begin
				cmd.re   = 1'b1;
				cmd.addr = ram_addr(1'b0, i_q, k_q);
				state_d  = S_PIV_CMP;
			end
			S_PIV_CMP: begin
				cmd.op = OP_PIV_CMP;
				if (stat.piv_gt)
					best_d = i_q;
				if (i_q == n_eff) begin
					state_d = S_SWP_CHK;
				end else begin
					i_d     = i_q + IDX_W'(1);
					state_d = S_PIV_RD;
				end
			end
			S_SWP_CHK: begin
				sel_d   = 1'b0;
				j_d     = '0;
				state_d = (best_q == k_q) ? S_ELIM0 : S_SW_RA;
			end
			S_SW_RA: begin
				cmd.re   = 1'b1;
				cmd.addr = ram_addr(sel_q, k_q, j_q);
				state_d  = S_SW_RB;
			end
			S_SW_RB: begin
				cmd.op   = OP_HOLD;
				cmd.re   = 1'b1;
				cmd.addr = ram_addr(sel_q, best_q, j_q);
				state_d  = S_SW_WA;
			end
			S_SW_WA: begin
				cmd.op   = OP_WR_RD;
				cmd.addr = ram_addr(sel_q, k_q, j_q);
				state_d  = S_SW_WB;
			end
			S_SW_WB: begin
				cmd.op   = OP_WR_HOLD;
				cmd.addr = ram_addr(sel_q, best_q, j_q);
				state_d  = S_SW_RA;
				if (j_q == n_eff) begin
					j_d = '0;
					if (sel_q)
						state_d = S_ELIM0;
					else
						sel_d = 1'b1;
				end else begin
					j_d = j_q + IDX_W'(1);
				end
			end
			S_ELIM0: begin
				if (k_q == n_eff) begin
					bk_d    = 1'b1;
					state_d = S_BK_K;
				end else begin
					bk_d    = 1'b0;
					i_d     = k_q + IDX_W'(1);
					state_d = S_DV_RA;
				end
			end
			S_DV_RA: begin
				cmd.re   = 1'b1;
				cmd.addr = ram_addr(1'b0, i_q, k_q);
				state_d  = S_DV_RB;
			end
			S_DV_RB: begin
				cmd.op   = OP_HOLD;
				cmd.re   = 1'b1;
				cmd.addr = ram_addr(1'b0, k_q, k_q);
				state_d  = S_DV_GO;
			end
			S_DV_GO: begin
				cmd.op  = OP_DIV_START;
				state_d = S_DV_W;
			end
			S_DV_W: begin
				if (stat.div_done) begin
					cmd.op  = OP_SET_C;
					sel_d   = bk_q;
					j_d     = bk_q ? '0 : k_q;
					state_d = S_RO_RS;
				end
			end
			S_RO_RS: begin
				cmd.re   = 1'b1;
				cmd.addr = ram_addr(sel_q, k_q, j_q);
				state_d  = S_RO_MG;
			end
			S_RO_MG: begin
				cmd.op  = OP_MUL_C;
				state_d = S_RO_MW;
			end
			S_RO_MW: begin
				if (stat.mul_done)
					state_d = S_RO_RD;
			end
			S_RO_RD: begin
				cmd.re   = 1'b1;
				cmd.addr = ram_addr(sel_q, i_q, j_q);
				state_d  = S_RO_WR;
			end
			S_RO_WR: begin
				cmd.op   = OP_WR_SUB;
				cmd.addr = ram_addr(sel_q, i_q, j_q);
				state_d  = S_RO_RS;
				if (j_q == n_eff) begin
					j_d = '0;
					if (!sel_q) begin
						sel_d = 1'b1;
					end else if (!bk_q) begin
						if (i_q == n_eff) begin
							k_d     = k_q + IDX_W'(1);
							state_d = S_PIV0;
						end else begin
							i_d     = i_q + IDX_W'(1);
							state_d = S_DV_RA;
						end
					end else begin
						if (i_q + IDX_W'(1) == k_q) begin
							state_d = S_SC_RD;
						end else begin
							i_d     = i_q + IDX_W'(1);
							state_d = S_DV_RA;
						end
					end
				end else begin
					j_d = j_q + IDX_W'(1);
				end
			end
			S_BK_K: begin
				i_d     = '0;
				state_d = (k_q == '0) ? S_SC_RD : S_DV_RA;
			end
			S_SC_RD: begin
				cmd.re   = 1'b1;
				cmd.addr = ram_addr(1'b0, k_q, k_q);
				state_d  = S_SC_GO;
			end
			S_SC_GO: begin
				cmd.op  = OP_DIV_ONE;
				state_d = S_SC_W;
			end
			S_SC_W: begin
				if (stat.div_done) begin
					cmd.op  = OP_SET_C;
					j_d     = '0;
					state_d = S_SC_RS;
				end
			end
			S_SC_RS: begin
				cmd.re   = 1'b1;
				cmd.addr = ram_addr(1'b1, k_q, j_q);
				state_d  = S_SC_MG;
			end
			S_SC_MG: begin
				cmd.op  = OP_MUL_C;
				state_d = S_SC_MW;
			end
			S_SC_MW: begin
				if (stat.mul_done)
					state_d = S_SC_WR;
			end
			S_SC_WR: begin
				cmd.op   = OP_WR_MUL;
				cmd.addr = ram_addr(1'b1, k_q, j_q);
				state_d  = S_SC_RS;
				if (j_q == n_eff) begin
					if (k_q == '0) begin
						i_d     = '0;
						state_d = S_OUT0;
					end else begin
						k_d     = k_q - IDX_W'(1);
						state_d = S_BK_K;
					end
				end else begin
					j_d = j_q + IDX_W'(1);
				end
			end
			S_OUT0: begin
				cmd.op  = OP_ACC_CLR;
				k_d     = '0;
				state_d = S_OU_RD;
			end
			S_OU_RD: begin
				cmd.re   = 1'b1;
				cmd.addr = ram_addr(1'b1, i_q, k_q);
				state_d  = S_OU_MG;
			end
			S_OU_MG: begin
				cmd.op  = OP_MUL_MS;
				cmd.idx = PW'(k_q);
				state_d = S_OU_MW;
			end
			S_OU_MW: begin
				if (stat.mul_done) begin
					cmd.op = OP_ACC_X;
					if (k_q == n_eff) begin
						state_d = S_OU_EM;
					end else begin
						k_d     = k_q + IDX_W'(1);
						state_d = S_OU_RD;
					end
				end
			end
			S_OU_EM: begin
				// hold until the output register is free
				if (!stat.out_busy) begin
					cmd.op   = OP_EMIT;
					cmd.idx  = PW'(i_q);
					cmd.last = (i_q == n_eff);
					if (i_q == n_eff) begin
						state_d = S_CLR;
					end else begin
						i_d     = i_q + IDX_W'(1);
						state_d = S_OUT0;
					end
				end
			end
			S_CLR: begin
				cmd.op  = OP_CLEAR;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pk_q     <= '0;
			k_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			best_q   <= '0;
			sel_q    <= 1'b0;
			bk_q     <= 1'b0;
			last_q   <= 1'b0;
			degree_q <= 3'd1;
		end else begin
			state_q <= state_d;
			pk_q    <= pk_d;
			k_q     <= k_d;
			i_q     <= i_d;
			j_q     <= j_d;
			best_q  <= best_d;
			sel_q   <= sel_d;
			bk_q    <= bk_d;
			last_q  <= last_d;
			if (degree_we)
				degree_q <= degree_wdata;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/polynomial_least_squares_fit_core.sv
// Each sample request runs 15 power steps with 22 products on the shared 32x32 multiplier
// before the next request is taken.
// A last sample then runs the fit: O(dim^3) row updates plus one divide per eliminated
// entry and per pivot, then dim coefficients are sent.
// The core handles one request at a time; results wait in an output register.
// Reset (arst_n low) clears the sums, degree to 1 and all control state at once.
`default_nettype none
module polynomial_least_squares_fit_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               degree_we,
	input  wire logic [2:0]         degree_wdata,
	input  wire logic               sample_valid,
	output logic                    sample_stall,
	input  wire logic signed [31:0] sample_t,
	input  wire logic signed [31:0] sample_b,
	input  wire logic               last_sample,
	output logic                    coeff_valid,
	input  wire logic               coeff_stall,
	output logic             [2:0]  coeff_index,
	output logic signed      [63:0] coeff_value,
	output logic                    last_coeff,
	output logic                    singular
);
	import plsf_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	plsf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.degree_we    (degree_we),
		.degree_wdata (degree_wdata),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.last_sample  (last_sample),
		.stat         (stat),
		.cmd          (cmd)
	);

	plsf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.sample_t    (sample_t),
		.sample_b    (sample_b),
		.coeff_valid (coeff_valid),
		.coeff_stall (coeff_stall),
		.coeff_index (coeff_index),
		.coeff_value (coeff_value),
		.last_coeff  (last_coeff),
		.singular    (singular)
	);

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the polynomial least-squares fit core.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import plsf_pkg::*;

	localparam int  HOLD_CYCLES = 3000;
	localparam int  IDLE_TAIL   = 300;
	localparam int  CYCLE_LIMIT = 40000000;
	localparam int  ITEM_TARGET = 470;
	localparam int  QUIET_TAIL  = 60;

	typedef struct {
		bit                 wr_degree;
		logic [2:0]         degree;
		logic signed [31:0] t;
		logic signed [31:0] b;
		logic               last;
		int                 ntyped;
		logic [63:0]        typed0;
		logic [63:0]        typed1;
		logic               typed_sing;
	} plan_row_t;

	typedef struct {
		logic [2:0]  index;
		logic [63:0] value;
		logic        last;
		logic        sing;
	} coeff_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               degree_we = 0;
	logic [2:0]         degree_wdata = 0;
	logic               sample_valid = 0;
	logic               sample_stall;
	logic signed [31:0] sample_t = 0;
	logic signed [31:0] sample_b = 0;
	logic               last_sample = 0;
	logic               coeff_valid;
	logic               coeff_stall = 0;
	logic [2:0]         coeff_index;
	logic signed [63:0] coeff_value;
	logic               last_coeff;
	logic               singular;

	polynomial_least_squares_fit_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.degree_we(degree_we), .degree_wdata(degree_wdata),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.sample_t(sample_t), .sample_b(sample_b), .last_sample(last_sample),
		.coeff_valid(coeff_valid), .coeff_stall(coeff_stall),
		.coeff_index(coeff_index), .coeff_value(coeff_value),
		.last_coeff(last_coeff), .singular(singular)
	);

	always #1 clk = ~clk;

	// predictor state
	logic [63:0] pwr_sum [NPOW];
	logic [63:0] mom_sum [NDIM];
	logic [2:0]  cur_degree = 3'd1;
	bit          pivot_zero;
	coeff_t      pending_coeffs [$];
	plan_row_t   plan [$];
	int          mismatches = 0;
	int          cycles = 0;
	bit          quiet = 0;
	bit          hold_req = 0;

	function automatic logic [63:0] abs64(logic [63:0] x);
		return x[63] ? 64'd0 - x : x;
	endfunction

	function automatic logic [63:0] signed_of(bit neg, logic [63:0] m);
		if (!neg)
			return m[63] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
		return m[63] ? 64'h8000_0000_0000_0000 : 64'd0 - m;
	endfunction

	function automatic logic [63:0] q_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63])
			r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return r;
	endfunction

	function automatic logic [63:0] q_sub(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		r = a - b;
		if (a[63] != b[63] && r[63] != a[63])
			r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return r;
	endfunction

	// floor of the exact product, then saturate
	function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
		bit           neg;
		bit           over;
		logic [127:0] p;
		logic [63:0]  q;
		neg = a[63] != b[63];
		p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
		q = p[95:32];
		over = p[127:96] != 0;
		if (neg && p[31:0] != 0 && !over) begin
			if (&q)
				over = 1;
			else
				q = q + 1;
		end
		if (over)
			return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return signed_of(neg, q);
	endfunction

	// truncated quotient; a zero divisor flags the fit and gives zero
	function automatic logic [63:0] q_div(logic [63:0] a, logic [63:0] b);
		bit           neg;
		logic [127:0] q;
		if (b == 0) begin
			pivot_zero = 1;
			return 64'd0;
		end
		neg = a[63] != b[63];
		q = {32'd0, abs64(a), 32'd0} / {64'd0, abs64(b)};
		if (q[127:64] != 0)
			return neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return signed_of(neg, q[63:0]);
	endfunction

	function automatic void solve_normal_equations();
		logic [63:0] wm [NDIM][NDIM];
		logic [63:0] im [NDIM][NDIM];
		logic [63:0] tmp, c, d, x;
		logic [63:0] best_mag;
		int          dim, best;
		coeff_t      r;
		dim = int'(cur_degree) + 1;
		pivot_zero = 0;
		for (int i = 0; i < dim; i++)
			for (int j = 0; j < dim; j++) begin
				wm[i][j] = pwr_sum[i + j];
				im[i][j] = (i == j) ? FX_ONE : 64'd0;
			end
		for (int k = 0; k < dim; k++) begin
			best = k;
			best_mag = abs64(wm[k][k]);
			for (int i = k + 1; i < dim; i++)
				if (abs64(wm[i][k]) > best_mag) begin
					best_mag = abs64(wm[i][k]);
					best = i;
				end
			for (int j = 0; j < dim; j++) begin
				tmp = wm[k][j]; wm[k][j] = wm[best][j]; wm[best][j] = tmp;
				tmp = im[k][j]; im[k][j] = im[best][j]; im[best][j] = tmp;
			end
			for (int i = k + 1; i < dim; i++) begin
				c = q_div(wm[i][k], wm[k][k]);
				for (int j = k; j < dim; j++)
					wm[i][j] = q_sub(wm[i][j], q_mul(c, wm[k][j]));
				for (int j = 0; j < dim; j++)
					im[i][j] = q_sub(im[i][j], q_mul(c, im[k][j]));
			end
		end
		for (int k = dim - 1; k >= 0; k--) begin
			for (int i = 0; i < k; i++) begin
				c = q_div(wm[i][k], wm[k][k]);
				for (int j = 0; j < dim; j++)
					im[i][j] = q_sub(im[i][j], q_mul(c, im[k][j]));
			end
			d = q_div(FX_ONE, wm[k][k]);
			for (int j = 0; j < dim; j++)
				im[k][j] = q_mul(im[k][j], d);
		end
		for (int i = 0; i < dim; i++) begin
			x = 0;
			for (int k = 0; k < dim; k++)
				x = q_add(x, q_mul(im[i][k], mom_sum[k]));
			r.index = i[2:0];
			r.value = x;
			r.last = (i == dim - 1);
			r.sing = pivot_zero;
			pending_coeffs.push_back(r);
		end
		for (int i = 0; i < NPOW; i++)
			pwr_sum[i] = 0;
		for (int i = 0; i < NDIM; i++)
			mom_sum[i] = 0;
	endfunction

	function automatic void absorb_sample(plan_row_t e);
		logic [63:0] t, b, p;
		coeff_t      r;
		t = {{16{e.t[31]}}, e.t, 16'd0};
		b = {{16{e.b[31]}}, e.b, 16'd0};
		p = FX_ONE;
		for (int k = 0; k < NPOW; k++) begin
			pwr_sum[k] = q_add(pwr_sum[k], p);
			if (k < NDIM)
				mom_sum[k] = q_add(mom_sum[k], q_mul(b, p));
			p = q_mul(p, t);
		end
		if (!e.last)
			return;
		if (e.ntyped == 0) begin
			solve_normal_equations();
			return;
		end
		// drop the accumulated sums and expect the hand-written coefficients instead
		for (int i = 0; i < NPOW; i++)
			pwr_sum[i] = 0;
		for (int i = 0; i < NDIM; i++)
			mom_sum[i] = 0;
		for (int i = 0; i < e.ntyped; i++) begin
			r.index = i[2:0];
			r.value = (i == 0) ? e.typed0 : e.typed1;
			r.last = (i == e.ntyped - 1);
			r.sing = e.typed_sing;
			pending_coeffs.push_back(r);
		end
	endfunction

	function automatic plan_row_t mk(logic signed [31:0] t, logic signed [31:0] b,
		logic last);
		plan_row_t e;
		e = '{default: 0};
		e.t = t;
		e.b = b;
		e.last = last;
		return e;
	endfunction

	function automatic logic signed [31:0] rand_q16();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h20000)) - 32'sh10000;
			default: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
		endcase
	endfunction

	task automatic set_degree(logic [2:0] d);
		plan_row_t e;
		e = '{default: 0};
		e.wr_degree = 1;
		e.degree = d;
		plan.push_back(e);
	endtask

	task automatic build_plan();
		plan_row_t e;
		int        deg, n, items;
		// reset degree, all-zero sample: rank one short, so singular and zero
		e = mk(0, 0, 1);
		e.ntyped = 2; e.typed0 = 0; e.typed1 = 0; e.typed_sing = 1;
		plan.push_back(e);
		// degree zero: the fit of one sample is its value
		set_degree(0);
		e = mk(32'sh0001_2345, 32'sh0003_0000, 1);
		e.ntyped = 1; e.typed0 = 64'h0000_0003_0000_0000;
		plan.push_back(e);
		e = mk(32'sh7FFF_FFFF, 32'sh8000_0000, 1);
		e.ntyped = 1; e.typed0 = 64'hFFFF_8000_0000_0000;
		plan.push_back(e);
		e = mk(32'sh8000_0000, 32'sh7FFF_FFFF, 1);
		e.ntyped = 1; e.typed0 = 64'h0000_7FFF_FFFF_0000;
		plan.push_back(e);
		// top degree with extreme abscissas: powers saturate
		set_degree(7);
		plan.push_back(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
		plan.push_back(mk(32'sh8000_0000, 32'sh8000_0000, 0));
		plan.push_back(mk(32'sh0000_0001, 32'sh0000_0001, 1));
		// clean quadratic through four points
		set_degree(2);
		plan.push_back(mk(-32'sh10000, 32'sh30000, 0));
		plan.push_back(mk(0, 32'sh10000, 0));
		plan.push_back(mk(32'sh10000, 32'sh30000, 0));
		plan.push_back(mk(32'sh20000, 32'sh90000, 1));
		// fewer samples than coefficients
		set_degree(3);
		plan.push_back(mk(32'sh8000, -32'sh18000, 0));
		plan.push_back(mk(32'sh28000, 32'sh4000, 1));
		// repeated abscissa: zero pivot
		set_degree(5);
		plan.push_back(mk(32'sh10000, 32'sh10000, 0));
		plan.push_back(mk(32'sh10000, 32'sh20000, 0));
		plan.push_back(mk(32'sh10000, 32'sh30000, 1));
		items = 16;
		while (items < ITEM_TARGET) begin
			if ($urandom_range(0, 2) == 0) begin
				deg = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3);
				set_degree(deg[2:0]);
			end
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 15) == 0)
					e = mk($urandom, $urandom, i == n - 1);
				else
					e = mk(rand_q16(), rand_q16(), i == n - 1);
				plan.push_back(e);
				items++;
			end
		end
		// the last set must close with a fit
		set_degree(7);
		plan.push_back(mk(rand_q16(), rand_q16(), 1));
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		coeff_t want;
		if (arst_n && coeff_valid && !coeff_stall) begin
			if (pending_coeffs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected coefficient idx=%0d val=%h", coeff_index, coeff_value);
			end else begin
				want = pending_coeffs.pop_front();
				if (want.index !== coeff_index || want.value !== coeff_value
						|| want.last !== last_coeff || want.sing !== singular) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"coeff mismatch: exp idx=%0d val=%h last=%b sing=%b,",
							" got idx=%0d val=%h last=%b sing=%b"},
							want.index, want.value, want.last, want.sing,
							coeff_index, coeff_value, last_coeff, singular);
				end
			end
		end
	end

	// receiver: random stall bursts, one long hold-off to back up the core
	initial begin
		bit held;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1;
				coeff_stall <= 1;
				repeat (HOLD_CYCLES) @(posedge clk);
				coeff_stall <= 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				coeff_stall <= 1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				coeff_stall <= 0;
			end
		end
	end

	initial begin
		plan_row_t e;
		int        n_rows;
		for (int i = 0; i < NPOW; i++)
			pwr_sum[i] = 0;
		for (int i = 0; i < NDIM; i++)
			mom_sum[i] = 0;
		build_plan();
		n_rows = plan.size();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int r = 0; r < n_rows; r++) begin
			e = plan[r];
			if (r == 30)
				hold_req = 1;
			if (r >= n_rows - QUIET_TAIL)
				quiet = 1;
			if (e.wr_degree) begin
				// wait for the core to go idle before touching the degree
				sample_valid <= 0;
				while (pending_coeffs.size() != 0)
					@(posedge clk);
				repeat (200) @(posedge clk);
				degree_we <= 1;
				degree_wdata <= e.degree;
				@(posedge clk);
				degree_we <= 0;
				cur_degree = e.degree;
				continue;
			end
			if (!quiet && r > 16 && $urandom_range(0, 3) == 0) begin
				sample_valid <= 0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			sample_valid <= 1;
			sample_t <= e.t;
			sample_b <= e.b;
			last_sample <= e.last;
			@(posedge clk);
			while (sample_stall)
				@(posedge clk);
			absorb_sample(e);
		end
		sample_valid <= 0;
		while (pending_coeffs.size() != 0)
			@(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
		if (mismatches == 0 && pending_coeffs.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
